// ----- rtl/tpf_pkg.sv -----
// Package for the text punctuation tokenizer filter: request types and token tables.
`timescale 1ns / 1ps
package tpf_pkg;

  // Width of the index into a token's characters.
  localparam int unsigned TOK_IDX_W = 4;

  localparam int unsigned TOK_STOP_LEN  = 11;
  localparam int unsigned TOK_COMMA_LEN = 8;
  localparam int unsigned TOK_QUEST_LEN = 11;

  // Classified byte kinds that produce output.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_COMMA = 2'd2,
    KIND_QUEST = 2'd3
  } kind_e;

  // One queued request from the front end to the emitter.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  // Character codes used by the classifier.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;

  // " <fullstop>"
  localparam logic [7:0] TOK_STOP [TOK_STOP_LEN] = '{
    8'h20, 8'h3C, 8'h66, 8'h75, 8'h6C, 8'h6C, 8'h73, 8'h74, 8'h6F, 8'h70, 8'h3E
  };
  // " <comma>"
  localparam logic [7:0] TOK_COMMA [TOK_COMMA_LEN] = '{
    8'h20, 8'h3C, 8'h63, 8'h6F, 8'h6D, 8'h6D, 8'h61, 8'h3E
  };
  // " <question>"
  localparam logic [7:0] TOK_QUEST [TOK_QUEST_LEN] = '{
    8'h20, 8'h3C, 8'h71, 8'h75, 8'h65, 8'h73, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h3E
  };

  // Number of output bytes for a request kind.
  function automatic logic [TOK_IDX_W-1:0] tok_len(input kind_e kind);
    logic [TOK_IDX_W-1:0] len;
    unique case (kind)
      KIND_CHAR:  len = TOK_IDX_W'(1);
      KIND_STOP:  len = TOK_IDX_W'(TOK_STOP_LEN);
      KIND_COMMA: len = TOK_IDX_W'(TOK_COMMA_LEN);
      KIND_QUEST: len = TOK_IDX_W'(TOK_QUEST_LEN);
      default:    len = TOK_IDX_W'(1);
    endcase
    return len;
  endfunction

  // Output byte at position idx of a request.
  function automatic logic [7:0] tok_char(input cmd_t cmd, input logic [TOK_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = CH_SPACE;
    unique case (cmd.kind)
      KIND_CHAR: ch = cmd.data;
      KIND_STOP: begin
        if (idx < TOK_IDX_W'(TOK_STOP_LEN)) ch = TOK_STOP[idx];
      end
      KIND_COMMA: begin
        if (idx < TOK_IDX_W'(TOK_COMMA_LEN)) ch = TOK_COMMA[idx[2:0]];
      end
      KIND_QUEST: begin
        if (idx < TOK_IDX_W'(TOK_QUEST_LEN)) ch = TOK_QUEST[idx];
      end
      default: ch = cmd.data;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/text_punct_tokenizer_filter.sv -----
// Top level of the text punctuation tokenizer filter.
// Usage:
//   Input channel (in_valid_i / in_stall_o): one text byte per request with
//   string_start_i marking the first byte of a new string. Bytes other than
//   ASCII letters, digits, period, comma, question mark, hyphen, space and
//   newline are dropped; repeated spaces collapse to one.
//   Output channel (out_valid_o / out_stall_i): one byte per request, last_o
//   high on the final byte produced for an input byte. A period, comma or
//   question mark expands into " <fullstop>", " <comma>" or " <question>".
//   A kept byte accepted on the input is written into the request queue,
//   then loaded into the output register. A plain byte yields one output
//   byte, so one byte per cycle is sustained while out_stall_i is low; the
//   emitter walks a token one character per cycle, also while out_stall_i is
//   low. Meanwhile input is accepted into a QueueDepth-entry request queue;
//   in_stall_o rises when it is full. Dropped bytes never enter the queue.
//   When the receiver stalls, the output register holds its byte and the
//   queue absorbs input until full. Reset empties the queue and the output
//   register and clears the space state; no clearing pass is needed.
`timescale 1ns / 1ps
module text_punct_tokenizer_filter #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int unsigned CmdW = $bits(tpf_pkg::cmd_t);

  tpf_pkg::cmd_t   push_cmd;
  tpf_pkg::cmd_t   head_cmd;
  logic [CmdW-1:0] head_raw;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  tpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .string_start_i (string_start_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  tpf_fifo #(
    .Depth (QueueDepth),
    .Width (CmdW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (head_raw)
  );

  assign head_cmd = tpf_pkg::cmd_t'(head_raw);

  tpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // Queue is never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("push into full request queue");

  // Queue is never popped when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("pop from empty request queue");

  // A token is emitted without gaps once started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap inside token expansion");

endmodule

// ----- rtl/tpf_fifo.sv -----
// Small request queue between the classifier and the emitter.
`timescale 1ns / 1ps
module tpf_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // Pointer and occupancy update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/tpf_front.sv -----
// Front end: accepts input bytes, tracks the space state and classifies each byte.
`timescale 1ns / 1ps
module tpf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          string_start_i,
  input  logic          q_full_i,
  output logic          push_o,
  output tpf_pkg::cmd_t cmd_o
);

  logic prev_space_q, prev_space_d;
  logic accept;
  logic eff_prev;
  logic keep;
  logic is_alnum;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign eff_prev   = string_start_i ? 1'b0 : prev_space_q;

  assign is_alnum = ((in_byte_i >= tpf_pkg::CH_0)  && (in_byte_i <= tpf_pkg::CH_9))  ||
                    ((in_byte_i >= tpf_pkg::CH_UA) && (in_byte_i <= tpf_pkg::CH_UZ)) ||
                    ((in_byte_i >= tpf_pkg::CH_LA) && (in_byte_i <= tpf_pkg::CH_LZ));

  // Classify the byte and work out the next space state
  always_comb begin
    keep         = 1'b0;
    cmd_o.kind   = tpf_pkg::KIND_CHAR;
    cmd_o.data   = in_byte_i;
    prev_space_d = eff_prev;
    priority if (in_byte_i == tpf_pkg::CH_SPACE) begin
      keep         = !eff_prev;
      prev_space_d = 1'b1;
    end else if (in_byte_i == tpf_pkg::CH_PERIOD) begin
      keep         = 1'b1;
      cmd_o.kind   = tpf_pkg::KIND_STOP;
      prev_space_d = 1'b0;
    end else if (in_byte_i == tpf_pkg::CH_COMMA) begin
      keep         = 1'b1;
      cmd_o.kind   = tpf_pkg::KIND_COMMA;
      prev_space_d = 1'b0;
    end else if (in_byte_i == tpf_pkg::CH_QUEST) begin
      keep         = 1'b1;
      cmd_o.kind   = tpf_pkg::KIND_QUEST;
      prev_space_d = 1'b0;
    end else if (is_alnum || (in_byte_i == tpf_pkg::CH_HYPHEN) ||
                 (in_byte_i == tpf_pkg::CH_NEWLINE)) begin
      keep         = 1'b1;
      prev_space_d = 1'b0;
    end else begin
      // dropped byte: only the string start clears the state
      keep = 1'b0;
    end
  end

  assign push_o = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_space_q <= 1'b0;
    end else if (accept) begin
      prev_space_q <= prev_space_d;
    end
  end

endmodule

// ----- rtl/tpf_back.sv -----
// Back end: expands queued requests into output bytes through an output register.
`timescale 1ns / 1ps
module tpf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tpf_pkg::cmd_t q_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);

  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_byte_q, out_byte_d;
  logic                          last_q, last_d;
  logic [tpf_pkg::TOK_IDX_W-1:0] idx_q, idx_d;
  logic                          load;
  logic                          is_last;

  // Output register can take a new byte when empty or being drained
  assign load    = !out_valid_q || !out_stall_i;
  assign is_last = (idx_q == tpf_pkg::tok_len(q_cmd_i.kind) - 1'b1);

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_empty_i;
      if (!q_empty_i) begin
        out_byte_d = tpf_pkg::tok_char(q_cmd_i, idx_q);
        last_d     = is_last;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule
